### design/csdf_pkg.sv
`default_nettype none

package csdf_pkg;

  localparam int VALUE_W = 7;
  localparam int TDATA_W = 8;
  localparam int TUSER_W = 2;

  // tuser bit positions on the result stream
  localparam int TUSER_NONE  = 0;
  localparam int TUSER_ERROR = 1;

  // commands from the controller, one per controller state
  typedef struct packed {
    logic load;
    logic fetch;
    logic load_cur;
    logic check;
    logic cmp;
    logic scan_rd;
    logic scan_cmp;
    logic fin;
  } cmd_t;

  // status from the datapath
  typedef struct packed {
    logic last_acc;
    logic bad_now;
    logic pos_ok;
    logic hit;
    logic at_end;
    logic dup;
    logic pend_valid;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### design/csdf_ram.sv
`default_nettype none

module csdf_ram
  #(parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1)
  (input  logic             clk,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/csdf_ctrl.sv
`default_nettype none

module csdf_ctrl
  import csdf_pkg::*;
  (input  logic clk,
   input  logic rst,
   input  sts_t sts,
   output cmd_t cmd);

  typedef enum logic [7:0] {
    ST_LOAD     = 8'b0000_0001,
    ST_FETCH    = 8'b0000_0010,
    ST_LOADCUR  = 8'b0000_0100,
    ST_CHECK    = 8'b0000_1000,
    ST_CMP      = 8'b0001_0000,
    ST_SCAN_RD  = 8'b0010_0000,
    ST_SCAN_CMP = 8'b0100_0000,
    ST_FIN      = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (sts.last_acc) begin
          state_next = sts.bad_now ? ST_FIN : ST_FETCH;
        end
      end
      ST_FETCH:   state_next = ST_LOADCUR;
      ST_LOADCUR: state_next = ST_CHECK;
      ST_CHECK: begin
        if (sts.pos_ok) begin
          state_next = sts.at_end ? ST_SCAN_RD : ST_FETCH;
        end else begin
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts.hit) begin
          state_next = sts.at_end ? ST_SCAN_RD : ST_FETCH;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_SCAN_RD: state_next = ST_SCAN_CMP;
      ST_SCAN_CMP: begin
        if (!(sts.dup && sts.pend_valid && !sts.out_free)) begin
          state_next = sts.at_end ? ST_FIN : ST_SCAN_RD;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = (state == ST_LOAD);
    cmd.fetch    = (state == ST_FETCH);
    cmd.load_cur = (state == ST_LOADCUR);
    cmd.check    = (state == ST_CHECK);
    cmd.cmp      = (state == ST_CMP);
    cmd.scan_rd  = (state == ST_SCAN_RD);
    cmd.scan_cmp = (state == ST_SCAN_CMP);
    cmd.fin      = (state == ST_FIN);
  end

  // a bad list skips sorting and goes straight to the single error result
  a_bad_to_fin: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && sts.last_acc && sts.bad_now) |=> (state == ST_FIN))
    else $error("bad list did not go to final result");

  // a swap step keeps the position open
  a_swap_back: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP && !sts.hit) |=> (state == ST_CHECK))
    else $error("swap did not return to check");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("controller state not one-hot");

endmodule

`default_nettype wire

### design/csdf_datapath.sv
`default_nettype none

module csdf_datapath
  import csdf_pkg::*;
  #(parameter int MAX_COUNT = 64)
  (input  logic               clk,
   input  logic               rst,
   input  cmd_t               cmd,
   output sts_t               sts,
   input  logic               s_tvalid,
   input  logic [VALUE_W-1:0] value,
   input  logic               s_last,
   output logic               m_tvalid,
   input  logic               m_tready,
   output logic [VALUE_W-1:0] dup_value,
   output logic               final_res,
   output logic               none,
   output logic               error);

  localparam int AW   = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
  localparam int CW   = $clog2(MAX_COUNT + 1);
  localparam int CMPW = ((CW > VALUE_W) ? CW : VALUE_W) + 1;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_COUNT);

  // list state
  logic [CW-1:0]      len;
  logic               ovf;
  logic               zero_seen;
  logic [VALUE_W-1:0] maxv;
  logic               bad;

  // sort and scan
  logic [AW-1:0]      idx;
  logic [VALUE_W-1:0] cur;
  logic               pend_valid;
  logic [VALUE_W-1:0] pend;

  // memory ports
  logic               we;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic [AW-1:0]      raddr;
  logic [VALUE_W-1:0] rdata;

  logic               acc;
  logic               room;
  logic [CW-1:0]      n_new;
  logic [VALUE_W-1:0] maxv_new;
  logic [CMPW-1:0]    cur_x;
  logic [CMPW-1:0]    j_x;
  logic [AW-1:0]      j;
  logic [CMPW-1:0]    pos_x;
  logic               push;
  logic [VALUE_W-1:0] push_dup;
  logic               push_fin;
  logic               push_none;
  logic               push_err;

  csdf_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_COUNT)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    acc      = cmd.load && s_tvalid;
    room     = (len < MAX_C);
    n_new    = room ? CW'(len + CW'(1)) : len;
    maxv_new = (room && (value > maxv)) ? value : maxv;
    cur_x    = CMPW'(cur);
    j_x      = cur_x - CMPW'(1);
    j        = j_x[AW-1:0];
    pos_x    = CMPW'(idx) + CMPW'(1);

    sts            = '0;
    sts.last_acc   = acc && s_last;
    sts.bad_now    = ovf || !room || zero_seen || (room && (value == '0)) ||
                     (CMPW'(maxv_new) > CMPW'(n_new));
    sts.pos_ok     = (cur_x == pos_x);
    sts.hit        = (rdata == cur);
    sts.at_end     = (pos_x == CMPW'(len));
    sts.dup        = (CMPW'(rdata) != pos_x);
    sts.pend_valid = pend_valid;
    sts.out_free   = !m_tvalid || m_tready;
  end

  // memory write and read addressing
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = cur;
    if (acc && room) begin
      we    = 1'b1;
      waddr = len[AW-1:0];
      wdata = value;
    end else if (cmd.check && sts.pos_ok) begin
      we = 1'b1;
    end else if (cmd.cmp) begin
      we    = 1'b1;
      waddr = sts.hit ? idx : j;
    end
    // the scan keeps re-reading its position while the output is held
    raddr = (cmd.fetch || cmd.scan_rd || cmd.scan_cmp) ? idx : j;
  end

  // result push, either an intermediate duplicate or the closing result
  always_comb begin
    push      = 1'b0;
    push_dup  = pend;
    push_fin  = 1'b0;
    push_none = 1'b0;
    push_err  = 1'b0;
    if (cmd.scan_cmp && sts.dup && pend_valid && sts.out_free) begin
      push = 1'b1;
    end else if (cmd.fin && sts.out_free) begin
      push     = 1'b1;
      push_fin = 1'b1;
      if (bad) begin
        push_dup = '0;
        push_err = 1'b1;
      end else if (!pend_valid) begin
        push_dup  = '0;
        push_none = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len        <= '0;
      ovf        <= 1'b0;
      zero_seen  <= 1'b0;
      maxv       <= '0;
      bad        <= 1'b0;
      idx        <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (acc) begin
        if (room) begin
          len  <= n_new;
          maxv <= maxv_new;
          if (value == '0) begin
            zero_seen <= 1'b1;
          end
        end else begin
          ovf <= 1'b1;
        end
        if (s_last) begin
          bad <= sts.bad_now;
          idx <= '0;
        end
      end

      if ((cmd.check && sts.pos_ok) || (cmd.cmp && sts.hit)) begin
        idx <= sts.at_end ? '0 : AW'(idx + AW'(1));
      end

      if (cmd.scan_cmp && !(sts.dup && pend_valid && !sts.out_free)) begin
        if (sts.dup) begin
          pend_valid <= 1'b1;
        end
        if (!sts.at_end) begin
          idx <= AW'(idx + AW'(1));
        end
      end

      if (cmd.fin && sts.out_free) begin
        len        <= '0;
        ovf        <= 1'b0;
        zero_seen  <= 1'b0;
        maxv       <= '0;
        bad        <= 1'b0;
        idx        <= '0;
        pend_valid <= 1'b0;
      end

      if (push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_cur) begin
      cur <= rdata;
    end else if (cmd.cmp && !sts.hit) begin
      cur <= rdata;
    end
    if (cmd.scan_cmp && sts.dup && !(pend_valid && !sts.out_free)) begin
      pend <= rdata;
    end
    if (push) begin
      dup_value <= push_dup;
      final_res <= push_fin;
      none      <= push_none;
      error     <= push_err;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= MAX_C)
    else $error("list length beyond store depth");

  a_clear_after_fin: assert property (@(posedge clk) disable iff (rst)
    (cmd.fin && sts.out_free) |=> (len == '0 && !pend_valid))
    else $error("list state not cleared after final result");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && error) |-> (final_res && !none && dup_value == '0))
    else $error("malformed error result");

  a_none_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && none) |-> (final_res && !error && dup_value == '0))
    else $error("malformed no-duplicate result");

endmodule

`default_nettype wire

### design/cyclic_sort_duplicate_finder.sv
// loading: one item per cycle; after the last item the sort fetches, loads and checks each
// position, compares an out-of-place value with its home slot and swaps until the position
// holds its own value or a repeat; the scan reads and compares each position, can be held
// by an output stall and ends in the closing result; a bad list skips both for its error result
// throughput: one list at a time, paced by one registered store read a cycle; a new
// list is taken once the closing result is registered; reset: synchronous, active high
`default_nettype none

module cyclic_sort_duplicate_finder
  import csdf_pkg::*;
  #(parameter int MAX_COUNT = 64)
  (input  logic               clk,
   input  logic               rst,
   // list element stream
   input  logic               s_tvalid,
   output logic               s_tready,
   input  logic [TDATA_W-1:0] s_tdata,  // [6:0] value, [7] unused
   input  logic               s_tlast,  // final element of the list
   // result stream
   output logic               m_tvalid,
   input  logic               m_tready,
   output logic [TDATA_W-1:0] m_tdata,  // [6:0] dup_value, [7] zero
   output logic               m_tlast,  // final_res, last result for this list
   output logic [TUSER_W-1:0] m_tuser); // [0] none, [1] error

  cmd_t               cmd;
  sts_t               sts;
  logic [VALUE_W-1:0] dup_value;
  logic               none;
  logic               error;

  // controller: walks load, sort, scan and closing result
  csdf_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // datapath: store, range check, swap engine and output register
  csdf_datapath #(.MAX_COUNT(MAX_COUNT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tvalid  (s_tvalid),
    .value     (s_tdata[VALUE_W-1:0]),
    .s_last    (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .dup_value (dup_value),
    .final_res (m_tlast),
    .none      (none),
    .error     (error)
  );

  // elements are only taken while loading
  assign s_tready = cmd.load;

  // pad the result to a whole byte
  assign m_tdata = {{(TDATA_W - VALUE_W){1'b0}}, dup_value};

  always_comb begin
    m_tuser              = '0;
    m_tuser[TUSER_NONE]  = none;
    m_tuser[TUSER_ERROR] = error;
  end

endmodule

`default_nettype wire
